>>> hdl/sssd_pkg.sv
// Shared types, constants and the segment table of the seven-segment serial driver.
package sssd_pkg;

    localparam int MAX_MODULES     = 4;
    localparam int BITS_PER_MODULE = 8;
    localparam int PATTERN_W       = MAX_MODULES * BITS_PER_MODULE;
    localparam int COUNT_W         = $clog2(PATTERN_W + 1);
    localparam int MODS_W          = 3;
    localparam int NUMBER_W        = 16;

    // n / 10 == (n * RECIP10) >> RECIP10_SHIFT for every n below 81920
    localparam logic [15:0] RECIP10       = 16'd52429;
    localparam int          RECIP10_SHIFT = 19;
    // q / 10 == (q * RECIP10_SMALL) >> RECIP10_SMALL_SHIFT for q below 1029
    localparam logic [7:0]  RECIP10_SMALL       = 8'd205;
    localparam int          RECIP10_SMALL_SHIFT = 11;

    localparam logic OP_NUMBER  = 1'b0;
    localparam logic OP_PATTERN = 1'b1;

    typedef struct packed {
        logic [PATTERN_W-1:0] pattern;
        logic [COUNT_W-1:0]   nbits;
    } frame_t;

    // Segment A in the MSB, DP in the LSB, active high
    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0:    seg = 8'hFC;
            4'd1:    seg = 8'h60;
            4'd2:    seg = 8'hDA;
            4'd3:    seg = 8'hF2;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'hB6;
            4'd6:    seg = 8'hBE;
            4'd7:    seg = 8'hE0;
            4'd8:    seg = 8'hFE;
            4'd9:    seg = 8'hF6;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

>>> hdl/sssd_format_pipe.sv
// Five-stage pipeline that turns a number or raw pattern into a masked segment frame.
module sssd_format_pipe (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  operation,
    input  logic [sssd_pkg::NUMBER_W-1:0]         number,
    input  logic [sssd_pkg::PATTERN_W-1:0]        pattern,
    input  logic [sssd_pkg::MODS_W-1:0]           num_modules,
    output logic                                  frame_valid,
    input  logic                                  frame_ready,
    output sssd_pkg::frame_t                      frame
);

    // Stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic v1_next, v2_next, v3_next, v4_next, v5_next;
    logic adv1, adv2, adv3, adv4, adv5;

    // Stage 1: captured item
    logic                               s1_op_reg, s1_op_next;
    logic [sssd_pkg::NUMBER_W-1:0]      s1_num_reg, s1_num_next;
    logic [sssd_pkg::PATTERN_W-1:0]     s1_pat_reg, s1_pat_next;
    logic [sssd_pkg::MODS_W-1:0]        s1_mods_reg, s1_mods_next;

    // Stage 2: first quotient and units digit
    logic                               s2_op_reg, s2_op_next;
    logic [12:0]                        s2_q_reg, s2_q_next;
    logic [3:0]                         s2_d0_reg, s2_d0_next;
    logic [sssd_pkg::PATTERN_W-1:0]     s2_pat_reg, s2_pat_next;
    logic [sssd_pkg::MODS_W-1:0]        s2_mods_reg, s2_mods_next;

    // Stage 3: tens digit
    logic                               s3_op_reg, s3_op_next;
    logic [9:0]                         s3_q_reg, s3_q_next;
    logic [3:0]                         s3_d0_reg, s3_d0_next;
    logic [3:0]                         s3_d1_reg, s3_d1_next;
    logic [sssd_pkg::PATTERN_W-1:0]     s3_pat_reg, s3_pat_next;
    logic [sssd_pkg::MODS_W-1:0]        s3_mods_reg, s3_mods_next;

    // Stage 4: hundreds digit
    logic                               s4_op_reg, s4_op_next;
    logic [6:0]                         s4_q_reg, s4_q_next;
    logic [3:0]                         s4_d0_reg, s4_d0_next;
    logic [3:0]                         s4_d1_reg, s4_d1_next;
    logic [3:0]                         s4_d2_reg, s4_d2_next;
    logic [sssd_pkg::PATTERN_W-1:0]     s4_pat_reg, s4_pat_next;
    logic [sssd_pkg::MODS_W-1:0]        s4_mods_reg, s4_mods_next;

    // Stage 5: finished frame
    sssd_pkg::frame_t                   s5_frame_reg, s5_frame_next;

    logic [31:0]                        prod2, prod3, prod4;
    logic [14:0]                        prod5;
    logic [3:0]                         q5;
    logic [3:0]                         d3;
    logic [sssd_pkg::PATTERN_W-1:0]     seg_pat, raw_pat, keep_mask;
    logic [sssd_pkg::MODS_W-1:0]        mods_sat;

    // Handshake: a stage moves when it is empty or the next one moves
    assign adv5     = !v5_reg || frame_ready;
    assign adv4     = !v4_reg || adv5;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_stall = !adv1;

    assign frame_valid = v5_reg;
    assign frame       = s5_frame_reg;

    assign mods_sat = (num_modules > sssd_pkg::MODS_W'(sssd_pkg::MAX_MODULES))
                    ? sssd_pkg::MODS_W'(sssd_pkg::MAX_MODULES) : num_modules;

    assign prod2 = 32'(s1_num_reg) * 32'(sssd_pkg::RECIP10);
    assign prod3 = 32'(s2_q_reg) * 32'(sssd_pkg::RECIP10);
    assign prod4 = 32'(s3_q_reg) * 32'(sssd_pkg::RECIP10);
    assign prod5 = 15'(s4_q_reg) * 15'(sssd_pkg::RECIP10_SMALL);
    assign q5    = prod5[sssd_pkg::RECIP10_SMALL_SHIFT +: 4];
    assign d3    = 4'(s4_q_reg - 7'({q5, 3'b000}) - 7'({q5, 1'b0}));

    // Keep only the bytes of the configured modules
    always_comb
    begin
        for (int i = 0; i < sssd_pkg::MAX_MODULES; i++)
        begin
            keep_mask[i*sssd_pkg::BITS_PER_MODULE +: sssd_pkg::BITS_PER_MODULE] =
                (sssd_pkg::MODS_W'(i) < s4_mods_reg) ? 8'hFF : 8'h00;
        end
    end

    always_comb
    begin
        seg_pat = {sssd_pkg::seg_of(d3), sssd_pkg::seg_of(s4_d2_reg),
                   sssd_pkg::seg_of(s4_d1_reg), sssd_pkg::seg_of(s4_d0_reg)};
        raw_pat = s4_pat_reg;
    end

    always_comb
    begin
        v1_next = adv1 ? in_valid : v1_reg;
        v2_next = adv2 ? v1_reg   : v2_reg;
        v3_next = adv3 ? v2_reg   : v3_reg;
        v4_next = adv4 ? v3_reg   : v4_reg;
        v5_next = adv5 ? v4_reg   : v5_reg;

        s1_op_next   = operation;
        s1_num_next  = number;
        s1_pat_next  = pattern;
        s1_mods_next = mods_sat;

        s2_op_next   = s1_op_reg;
        s2_q_next    = prod2[sssd_pkg::RECIP10_SHIFT +: 13];
        s2_d0_next   = 4'(s1_num_reg - 16'({s2_q_next, 3'b000}) - 16'({s2_q_next, 1'b0}));
        s2_pat_next  = s1_pat_reg;
        s2_mods_next = s1_mods_reg;

        s3_op_next   = s2_op_reg;
        s3_q_next    = prod3[sssd_pkg::RECIP10_SHIFT +: 10];
        s3_d0_next   = s2_d0_reg;
        s3_d1_next   = 4'(s2_q_reg - 13'({s3_q_next, 3'b000}) - 13'({s3_q_next, 1'b0}));
        s3_pat_next  = s2_pat_reg;
        s3_mods_next = s2_mods_reg;

        s4_op_next   = s3_op_reg;
        s4_q_next    = prod4[sssd_pkg::RECIP10_SHIFT +: 7];
        s4_d0_next   = s3_d0_reg;
        s4_d1_next   = s3_d1_reg;
        s4_d2_next   = 4'(s3_q_reg - 10'({s4_q_next, 3'b000}) - 10'({s4_q_next, 1'b0}));
        s4_pat_next  = s3_pat_reg;
        s4_mods_next = s3_mods_reg;

        s5_frame_next.pattern = ((s4_op_reg == sssd_pkg::OP_PATTERN) ? raw_pat : seg_pat)
                              & keep_mask;
        s5_frame_next.nbits   = sssd_pkg::COUNT_W'(s4_mods_reg)
                              * sssd_pkg::COUNT_W'(sssd_pkg::BITS_PER_MODULE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_op_reg   <= s1_op_next;
            s1_num_reg  <= s1_num_next;
            s1_pat_reg  <= s1_pat_next;
            s1_mods_reg <= s1_mods_next;
        end
        if (adv2)
        begin
            s2_op_reg   <= s2_op_next;
            s2_q_reg    <= s2_q_next;
            s2_d0_reg   <= s2_d0_next;
            s2_pat_reg  <= s2_pat_next;
            s2_mods_reg <= s2_mods_next;
        end
        if (adv3)
        begin
            s3_op_reg   <= s3_op_next;
            s3_q_reg    <= s3_q_next;
            s3_d0_reg   <= s3_d0_next;
            s3_d1_reg   <= s3_d1_next;
            s3_pat_reg  <= s3_pat_next;
            s3_mods_reg <= s3_mods_next;
        end
        if (adv4)
        begin
            s4_op_reg   <= s4_op_next;
            s4_q_reg    <= s4_q_next;
            s4_d0_reg   <= s4_d0_next;
            s4_d1_reg   <= s4_d1_next;
            s4_d2_reg   <= s4_d2_next;
            s4_pat_reg  <= s4_pat_next;
            s4_mods_reg <= s4_mods_next;
        end
        if (adv5)
        begin
            s5_frame_reg <= s5_frame_next;
        end
    end

    // A frame always carries whole bytes and never more than the chain holds
    assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg |-> (s5_frame_reg.nbits[2:0] == 3'd0 &&
                    s5_frame_reg.nbits <= sssd_pkg::COUNT_W'(sssd_pkg::PATTERN_W)))
        else $error("frame bit count malformed");

    // A stalled output stage keeps its frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && !frame_ready) |=> (v5_reg && $stable(s5_frame_reg)))
        else $error("frame dropped while held");

    // An item in stage 1 reaches stage 2 unless stage 2 is held
    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && adv2) |=> v2_reg)
        else $error("item lost between stages");

endmodule

>>> hdl/seven_segment_serial_driver.sv
// Top level of the seven-segment serial driver: config register, format pipeline, shifter.
//
// Usage:
//   Configuration: num_modules is written through cfg_valid/cfg_ready/cfg_data
//   (cfg_ready is always high). Values 5 to 7 act as 4; 0 sends nothing.
//   Write it only while no transaction is in flight.
//   Input: operation/number/pattern move as one transaction when in_valid is
//   high and in_stall is low. Operation 0 shows number in decimal, units digit
//   in module 0; operation 1 sends pattern bytes as they are.
//   Output: one transaction per serial bit on serial_data, taken when out_valid
//   is high and out_stall is low; last_bit marks the final bit of a run.
//   Path: an accepted item passes through the capture stage, then four format
//   stages, then the shift register, which puts its first bit on the output.
//   Throughput: an item is 8 x modules bits, at most 32, sent by the shift
//   register one bit per cycle while out_stall is low; with zero modules an
//   item sends nothing. The next frame loads in the cycle
//   the last bit leaves, so runs follow back to back with no gap, and the
//   format pipeline keeps accepting items behind the one being sent.
//   Reset: clears all valid bits and the shift count; num_modules returns to 4.
//   Stall: a stalled output holds its bit; the pipeline fills and then raises
//   in_stall. Nothing is dropped or repeated.
module seven_segment_serial_driver (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sssd_pkg::MODS_W-1:0]           cfg_data,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  operation,
    input  logic [sssd_pkg::NUMBER_W-1:0]         number,
    input  logic [sssd_pkg::PATTERN_W-1:0]        pattern,
    // output channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  serial_data,
    output logic                                  last_bit
);

    logic [sssd_pkg::MODS_W-1:0]    num_modules_reg, num_modules_next;
    logic [sssd_pkg::PATTERN_W-1:0] shift_reg, shift_next;
    logic [sssd_pkg::COUNT_W-1:0]   bits_left_reg, bits_left_next;

    logic             frame_valid;
    logic             frame_ready;
    sssd_pkg::frame_t frame;
    logic             out_take;

    // Configuration register: always ready
    assign cfg_ready        = 1'b1;
    assign num_modules_next = (cfg_valid && cfg_ready) ? cfg_data : num_modules_reg;

    sssd_format_pipe u_format (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .number      (number),
        .pattern     (pattern),
        .num_modules (num_modules_reg),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    // Shifter: present bit 0, drop it when the receiver takes it
    assign out_valid   = (bits_left_reg != '0);
    assign serial_data = shift_reg[0];
    assign last_bit    = (bits_left_reg == sssd_pkg::COUNT_W'(1));
    assign out_take    = out_valid && !out_stall;

    // Load the next frame when idle or as the final bit leaves
    assign frame_ready = !out_valid || (last_bit && !out_stall);

    always_comb
    begin
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        if (out_take)
        begin
            shift_next     = shift_reg >> 1;
            bits_left_next = bits_left_reg - sssd_pkg::COUNT_W'(1);
        end
        if (frame_ready && frame_valid)
        begin
            shift_next     = frame.pattern;
            bits_left_next = frame.nbits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_modules_reg <= sssd_pkg::MODS_W'(sssd_pkg::MAX_MODULES);
            bits_left_reg   <= '0;
            shift_reg       <= '0;
        end
        else
        begin
            num_modules_reg <= num_modules_next;
            bits_left_reg   <= bits_left_next;
            shift_reg       <= shift_next;
        end
    end

    // Count never exceeds the width of the chain
    assert property (@(posedge clk) disable iff (!rst_n)
        bits_left_reg <= sssd_pkg::COUNT_W'(sssd_pkg::PATTERN_W))
        else $error("bit count out of range");

    // After a final bit, either idle or a fresh whole-byte run
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && last_bit) |=> (bits_left_reg[2:0] == 3'd0))
        else $error("run did not restart on a byte boundary");

    // A taken bit that is not the last counts down by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && !last_bit) |=>
            (bits_left_reg == $past(bits_left_reg) - sssd_pkg::COUNT_W'(1)))
        else $error("bit count skipped");

    // A held bit stays in place with its count
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(bits_left_reg) && $stable(shift_reg)))
        else $error("shifter moved while stalled");

endmodule
